>>> rtl/lpfc_pkg.sv
// ----------------------------------------------------------------------------
// lpfc_pkg
// Shared types and constants of the lidar point to float converter.
// ----------------------------------------------------------------------------
package lpfc_pkg;

    typedef struct packed {
        logic [31:0] x_mm;
        logic [31:0] y_mm;
        logic [31:0] z_mm;
        logic [7:0]  reflectivity;
        logic [7:0]  point_tag;
        logic        last_in;
    } t_pt_in;

    typedef struct packed {
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] z_bits;
        logic [31:0] intensity_bits;
        logic [7:0]  tag_out;
        logic        last_out;
    } t_pt_out;

    // Pipeline depth from input register to output register.
    localparam int C_DEPTH = 5;

    // floor(2^39 / 125): reciprocal for the divide by 125 (the 8 goes to the exponent).
    localparam logic [32:0] C_RECIP_125 = 33'd4398046511;
    localparam logic [6:0]  C_DIV_125   = 7'd125;

    // Biased exponent of the metre value for a millimetre msb at bit 0.
    localparam logic [7:0] C_EXP_OFS = 8'd117;
    localparam logic [7:0] C_EXP_BIAS = 8'd127;

endpackage

>>> rtl/lidar_point_to_float_converter.sv
// One point word per clock: the block accepts a word every cycle unless the
// output stalls it, and a five-stage pipe per coordinate converts it (msb
// search, normalize and round, reciprocal multiply, remainder correction,
// final round). A stall on the output freezes the whole pipe and is passed
// back to the input the same cycle only while the output word is held.
// ----------------------------------------------------------------------------
// lidar_point_to_float_converter
// Converts millimetre int32 coordinates to float32 metres, intensity to float.
// ----------------------------------------------------------------------------
module lidar_point_to_float_converter
    import lpfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_pt_in  i_pt,
    output logic    o_valid,
    input  logic    i_stall,
    output t_pt_out o_res
);

    logic               en;
    logic [C_DEPTH-1:0] r_vld;
    logic [C_DEPTH-1:0] n_vld;
    logic [31:0]        n_int;
    logic [31:0]        r_int [C_DEPTH];
    logic [7:0]         r_tag [C_DEPTH];
    logic               r_last [C_DEPTH];
    logic [31:0]        x_bits, y_bits, z_bits;

    assign en      = !(r_vld[C_DEPTH-1] && i_stall);
    assign o_stall = !en;
    assign n_vld   = {r_vld[C_DEPTH-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    // intensity byte to float, exact
    always_comb begin
        logic [2:0]  pos;
        logic [22:0] frac;
        pos = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (i_pt.reflectivity[i]) begin
                pos = 3'(i);
            end
        end
        frac = {i_pt.reflectivity, 15'd0} << (4'd8 - {1'b0, pos});
        if (i_pt.reflectivity == 8'd0) begin
            n_int = 32'd0;
        end else begin
            n_int = {1'b0, C_EXP_BIAS + {5'd0, pos}, frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_int[0]  <= n_int;
            r_tag[0]  <= i_pt.point_tag;
            r_last[0] <= i_pt.last_in;
            for (int i = 1; i < C_DEPTH; i++) begin
                r_int[i]  <= r_int[i-1];
                r_tag[i]  <= r_tag[i-1];
                r_last[i] <= r_last[i-1];
            end
        end
    end

    lpfc_coord u_x (.i_clk(i_clk), .i_en(en), .i_mm(i_pt.x_mm), .o_bits(x_bits));
    lpfc_coord u_y (.i_clk(i_clk), .i_en(en), .i_mm(i_pt.y_mm), .o_bits(y_bits));
    lpfc_coord u_z (.i_clk(i_clk), .i_en(en), .i_mm(i_pt.z_mm), .o_bits(z_bits));

    assign o_valid              = r_vld[C_DEPTH-1];
    assign o_res.x_bits         = x_bits;
    assign o_res.y_bits         = y_bits;
    assign o_res.z_bits         = z_bits;
    assign o_res.intensity_bits = r_int[C_DEPTH-1];
    assign o_res.tag_out        = r_tag[C_DEPTH-1];
    assign o_res.last_out       = r_last[C_DEPTH-1];

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("input stalled with no output word held");

    a_no_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.x_bits[30:0] == 31'd0) |-> !o_res.x_bits[31])
        else $error("negative zero on x");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.y_bits != 32'd0) |->
        (o_res.y_bits[30:23] >= 8'd117 && o_res.y_bits[30:23] <= 8'd149))
        else $error("y exponent out of range");

endmodule

>>> rtl/lpfc_coord.sv
// ----------------------------------------------------------------------------
// lpfc_coord
// Five-stage pipe: int32 millimetres to float32 metres, both roundings RNE.
// ----------------------------------------------------------------------------
module lpfc_coord
    import lpfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_mm,
    output logic [31:0] o_bits
);

    // stage 1: sign, magnitude, msb position
    logic        r1_sign, r1_zero;
    logic [31:0] r1_abs;
    logic [4:0]  r1_pos;
    logic [31:0] n1_abs;
    logic [4:0]  n1_pos;

    always_comb begin
        n1_abs = i_mm[31] ? (32'd0 - i_mm) : i_mm;
        n1_pos = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (n1_abs[i]) begin
                n1_pos = 5'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sign <= i_mm[31];
            r1_zero <= (i_mm == 32'd0);
            r1_abs  <= n1_abs;
            r1_pos  <= n1_pos;
        end
    end

    // stage 2: normalize and round to 24 bits
    logic        r2_sign, r2_zero;
    logic [23:0] r2_man;
    logic [5:0]  r2_pos;
    logic [31:0] n2_norm;
    logic        n2_inc;
    logic [24:0] n2_sum;

    always_comb begin
        n2_norm = r1_abs << (5'd31 - r1_pos);
        n2_inc  = n2_norm[7] & ((|n2_norm[6:0]) | n2_norm[8]);
        n2_sum  = {1'b0, n2_norm[31:8]} + {24'd0, n2_inc};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sign <= r1_sign;
            r2_zero <= r1_zero;
            if (n2_sum[24]) begin
                r2_man <= {1'b1, 23'd0};
                r2_pos <= {1'b0, r1_pos} + 6'd1;
            end else begin
                r2_man <= n2_sum[23:0];
                r2_pos <= {1'b0, r1_pos};
            end
        end
    end

    // stage 3: estimate quotient of (man * 256) / 125 by reciprocal
    logic        r3_sign, r3_zero;
    logic [23:0] r3_man;
    logic [5:0]  r3_pos;
    logic [25:0] r3_q0;
    logic [56:0] n3_prod;

    assign n3_prod = {33'd0, r2_man} * {24'd0, C_RECIP_125};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sign <= r2_sign;
            r3_zero <= r2_zero;
            r3_man  <= r2_man;
            r3_pos  <= r2_pos;
            r3_q0   <= n3_prod[56:31];
        end
    end

    // stage 4: remainder check, correct the estimate by one
    logic        r4_sign, r4_zero, r4_sticky;
    logic [25:0] r4_q;
    logic [5:0]  r4_pos;
    logic [33:0] n4_t, n4_r;
    logic [8:0]  n4_rem;

    always_comb begin
        n4_t   = {1'b0, r3_q0, 7'd0} - {7'd0, r3_q0, 1'b0} - {8'd0, r3_q0};
        n4_r   = {2'd0, r3_man, 8'd0} - n4_t;
        n4_rem = n4_r[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sign <= r3_sign;
            r4_zero <= r3_zero;
            r4_pos  <= r3_pos;
            if (n4_rem >= {2'd0, C_DIV_125}) begin
                r4_q      <= r3_q0 + 26'd1;
                r4_sticky <= (n4_rem != {2'd0, C_DIV_125});
            end else begin
                r4_q      <= r3_q0;
                r4_sticky <= (n4_rem != 9'd0);
            end
        end
    end

    // stage 5: final rounding and packing
    logic [31:0] r5_bits;
    logic        n5_hi, n5_g, n5_s, n5_inc;
    logic [23:0] n5_man;
    logic [24:0] n5_sum;
    logic [7:0]  n5_exp;

    always_comb begin
        n5_hi = r4_q[25];
        if (n5_hi) begin
            n5_man = r4_q[25:2];
            n5_g   = r4_q[1];
            n5_s   = r4_q[0] | r4_sticky;
        end else begin
            n5_man = r4_q[24:1];
            n5_g   = r4_q[0];
            n5_s   = r4_sticky;
        end
        n5_inc = n5_g & (n5_s | n5_man[0]);
        n5_sum = {1'b0, n5_man} + {24'd0, n5_inc};
        n5_exp = {2'd0, r4_pos} + C_EXP_OFS + {7'd0, n5_hi} + {7'd0, n5_sum[24]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r4_zero) begin
                r5_bits <= 32'd0;
            end else begin
                // on carry out the fraction is all zeros
                r5_bits <= {r4_sign, n5_exp, n5_sum[24] ? 23'd0 : n5_sum[22:0]};
            end
        end
    end

    assign o_bits = r5_bits;

endmodule

>>> tb/sv/lidar_point_to_float_converter_tb.sv
// ----------------------------------------------------------------------------
// lidar_point_to_float_converter_tb
// Self-checking bench for the point converter.
// It streams directed corner points and random points through the valid/stall
// channels. Each accepted word is checked against a bit-exact predictor of
// the float conversion, with random idle gaps and stalls on both sides and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module lidar_point_to_float_converter_tb;
    import lpfc_pkg::*;

    // Round a real value (normal single range or zero) to IEEE single, ties to even.
    function automatic logic [31:0] real_to_single(real r);
        logic [63:0] d;
        logic [10:0] e;
        logic [51:0] m;
        logic [23:0] keep;
        logic [28:0] rem;
        logic [7:0]  se;
        d = $realtobits(r);
        e = d[62:52];
        m = d[51:0];
        if (e == 11'd0) begin
            return 32'h0000_0000;
        end
        se   = 8'(e - 11'd1023 + 11'd127);
        keep = {1'b0, m[51:29]};
        rem  = m[28:0];
        if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && keep[0])) begin
            keep = keep + 24'd1;
        end
        if (keep[23]) begin
            se   = se + 8'd1;
            keep = 24'd0;
        end
        return {d[63], se, keep[22:0]};
    endfunction

    // Round a 32-bit integer to the nearest single value and return it as real.
    function automatic real mm_as_single(logic signed [31:0] v);
        longint mag;
        longint keep;
        longint rem;
        longint half;
        int     msb;
        int     sh;
        mag = (v < 0) ? -longint'(v) : longint'(v);
        msb = 0;
        for (int k = 0; k < 33; k++) begin
            if (mag[k]) begin
                msb = k;
            end
        end
        if (msb > 23) begin
            sh   = msb - 23;
            keep = mag >> sh;
            rem  = mag & ((longint'(1) << sh) - 1);
            half = longint'(1) << (sh - 1);
            if (rem > half || (rem == half && keep[0])) begin
                keep = keep + 1;
            end
            mag = keep << sh;
        end
        return (v < 0) ? -real'(mag) : real'(mag);
    endfunction

    function automatic logic [31:0] mm_to_metre(logic [31:0] raw);
        return real_to_single(mm_as_single(raw) / 1000.0);
    endfunction

    class point_scoreboard;
        t_pt_out pending[$];
        int      n_errors;

        function void note_point(t_pt_in p);
            t_pt_out r;
            r.x_bits         = mm_to_metre(p.x_mm);
            r.y_bits         = mm_to_metre(p.y_mm);
            r.z_bits         = mm_to_metre(p.z_mm);
            r.intensity_bits = real_to_single(real'(p.reflectivity));
            r.tag_out        = p.point_tag;
            r.last_out       = p.last_in;
            pending.insert(pending.size(), r);
        endfunction

        function void check_word(t_pt_out got);
            t_pt_out exp_w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                n_errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.x_bits !== exp_w.x_bits) begin
                $display("%0t: x_bits exp %h got %h", $time, exp_w.x_bits, got.x_bits);
                n_errors++;
            end
            if (got.y_bits !== exp_w.y_bits) begin
                $display("%0t: y_bits exp %h got %h", $time, exp_w.y_bits, got.y_bits);
                n_errors++;
            end
            if (got.z_bits !== exp_w.z_bits) begin
                $display("%0t: z_bits exp %h got %h", $time, exp_w.z_bits, got.z_bits);
                n_errors++;
            end
            if (got.intensity_bits !== exp_w.intensity_bits) begin
                $display("%0t: intensity_bits exp %h got %h", $time,
                         exp_w.intensity_bits, got.intensity_bits);
                n_errors++;
            end
            if (got.tag_out !== exp_w.tag_out) begin
                $display("%0t: tag_out exp %h got %h", $time, exp_w.tag_out, got.tag_out);
                n_errors++;
            end
            if (got.last_out !== exp_w.last_out) begin
                $display("%0t: last_out exp %b got %b", $time, exp_w.last_out, got.last_out);
                n_errors++;
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_stall;
    t_pt_in  i_pt;
    logic    o_valid;
    logic    i_stall;
    t_pt_out o_res;

    point_scoreboard sb;
    logic            quiet;

    lidar_point_to_float_converter u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_pt   (i_pt),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_res  (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one word, optionally after an idle burst; return once accepted.
    task automatic send_point(t_pt_in p, bit may_idle);
        int gap;
        gap = (may_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_pt    <= t_pt_in'(113'({$urandom, $urandom, $urandom, $urandom}));
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_pt    <= p;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        sb.note_point(p);
    endtask

    function automatic logic [31:0] pick_mm();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 20000)) - 10000);
            2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
            default: return 32'($urandom) >>> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic t_pt_in mk_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic [7:0] refl, logic [7:0] tag, logic last);
        t_pt_in p;
        p.x_mm = x;
        p.y_mm = y;
        p.z_mm = z;
        p.reflectivity = refl;
        p.point_tag = tag;
        p.last_in = last;
        return p;
    endfunction

    // Receiver: random stall bursts, one long hold-off, none near the end.
    initial begin
        int cyc;
        int burst;
        cyc   = 0;
        burst = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc >= 400 && cyc < 700) begin
                i_stall <= 1'b1;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 10);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_word(o_res);
        end
    end

    initial begin
        t_pt_in p;
        int     waited;
        sb      = new();
        quiet   = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pt    = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero, unit steps, extremes, and the rounding points past 24 bits
        send_point(mk_point(32'd0, 32'd0, 32'd0, 8'd0, 8'd0, 1'b0), 1'b0);
        send_point(mk_point(32'd1, 32'hFFFF_FFFF, 32'd1000, 8'd255, 8'd255, 1'b1), 1'b0);
        send_point(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FC18, 8'd1, 8'd128,
                            1'b0), 1'b0);
        send_point(mk_point(32'd16777216, 32'd16777217, 32'd16777219, 8'd2, 8'd1, 1'b1),
                   1'b0);
        send_point(mk_point(32'd33554434, 32'd33554438, -32'sd16777217, 8'd127, 8'd254,
                            1'b0), 1'b0);
        send_point(mk_point(32'd16777215, -32'sd16777215, 32'd500, 8'd128, 8'd7, 1'b0),
                   1'b1);
        send_point(mk_point(32'd1500, -32'sd2500, 32'h8000_0001, 8'd100, 8'd55, 1'b1), 1'b1);
        send_point(mk_point(32'h7FFF_FFC0, 32'h7FFF_FF80, 32'h4000_0040, 8'd3, 8'd170,
                            1'b0), 1'b1);

        for (int n = 0; n < 500; n++) begin
            if (n == 420) quiet = 1'b1;
            p = mk_point(pick_mm(), pick_mm(), pick_mm(), 8'($urandom), 8'($urandom),
                         1'($urandom));
            send_point(p, !quiet);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (C_DEPTH + 5) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
